### sv/sfe_pkg.sv
`default_nettype none

package sfe_pkg;

  // Framing bytes
  localparam logic [7:0] HdrByte  = 8'hAA;
  localparam logic [7:0] TailByte = 8'h55;
  localparam logic [7:0] EscByte  = 8'hA5;

  // CRC-16, reflected form
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  // Configuration
  localparam int unsigned CfgAddrW        = 3;
  localparam logic        RegIdxMaxOutLen = 1'b0;
  localparam logic [15:0] MaxOutLenReset  = 16'd1024;

  // Queue depths
  localparam int unsigned JobDepthDefault = 4;
  localparam int unsigned OutDepthDefault = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
    logic       overflow;
  } out_item_t;

  // One classified payload byte handed from front to back
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        esc;
    logic        first;
    logic        last;
    logic [15:0] crc;
  } job_t;

  typedef enum logic [3:0] {
    ST_START,
    ST_HDR1,
    ST_HDR2,
    ST_DESC,
    ST_DATA,
    ST_LESC,
    ST_LO,
    ST_HESC,
    ST_HI,
    ST_TAIL1,
    ST_TAIL2,
    ST_OVF
  } step_e;

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == HdrByte) || (b == TailByte) || (b == EscByte);
  endfunction

endpackage

`default_nettype wire

### sv/sfe_fifo.sv
`default_nettype none

module sfe_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_ptr_q];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### sv/sfe_front.sv
`default_nettype none

module sfe_front
  import sfe_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire in_item_t in_item_i,
  output logic          full_o,
  output logic          job_push_o,
  output job_t          job_o,
  input  wire logic     job_full_i
);

  logic        in_frame_q, in_frame_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_base;
  logic        accept;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  assign full_o = job_full_i;
  assign accept = push_i && !job_full_i;

  // Restart the CRC on the first byte of a frame
  assign crc_base   = in_frame_q ? crc_q : CrcInit;
  assign crc_d      = accept ? crc_byte(crc_base, in_item_i.data_byte) : crc_q;
  assign in_frame_d = accept ? !in_item_i.frame_last : in_frame_q;

  // Classify the byte for the back end
  always_comb begin
    job_o.data_byte = in_item_i.data_byte;
    job_o.esc       = needs_esc(in_item_i.data_byte);
    job_o.first     = !in_frame_q;
    job_o.last      = in_item_i.frame_last;
    job_o.crc       = crc_byte(crc_base, in_item_i.data_byte);
  end
  assign job_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      crc_q      <= CrcInit;
    end else begin
      in_frame_q <= in_frame_d;
      crc_q      <= crc_d;
    end
  end

endmodule

`default_nettype wire

### sv/sfe_back.sv
`default_nettype none

module sfe_back
  import sfe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire job_t        job_i,
  input  wire logic        job_valid_i,
  output logic             job_pop_o,
  input  wire logic [15:0] max_out_len_i,
  input  wire logic        out_ready_i,
  output logic             out_push_o,
  output out_item_t        out_item_o
);

  step_e       step_q, step_d;
  step_e       eff_step, init_step, nom_step;
  logic        nom_end;
  logic [15:0] count_q, count_d;
  logic        ovf_q, ovf_d;
  logic        go, room, tail_room, more_room;
  logic [16:0] cnt_p1, cnt_p2;
  logic [7:0]  step_byte;

  assign go        = job_valid_i && out_ready_i;
  assign cnt_p1    = {1'b0, count_q} + 17'd1;
  assign cnt_p2    = {1'b0, count_q} + 17'd2;
  assign room      = !ovf_q && (count_q < max_out_len_i);
  assign tail_room = room && (cnt_p2 <= {1'b0, max_out_len_i});
  assign more_room = cnt_p1 < {1'b0, max_out_len_i};

  // Pick the first step of a fresh job
  assign init_step = job_i.first ? ST_HDR1 : (job_i.esc ? ST_DESC : ST_DATA);
  assign eff_step  = (step_q == ST_START) ? init_step : step_q;

  // Nominal sequence when nothing is suppressed
  always_comb begin
    nom_step = ST_START;
    nom_end  = 1'b0;
    unique case (eff_step)
      ST_HDR1:  nom_step = ST_HDR2;
      ST_HDR2:  nom_step = job_i.esc ? ST_DESC : ST_DATA;
      ST_DESC:  nom_step = ST_DATA;
      ST_DATA: begin
        if (job_i.last) begin
          nom_step = needs_esc(job_i.crc[7:0]) ? ST_LESC : ST_LO;
        end else begin
          nom_end = 1'b1;
        end
      end
      ST_LESC:  nom_step = ST_LO;
      ST_LO:    nom_step = needs_esc(job_i.crc[15:8]) ? ST_HESC : ST_HI;
      ST_HESC:  nom_step = ST_HI;
      ST_HI:    nom_step = ST_TAIL1;
      ST_TAIL1: nom_step = ST_TAIL2;
      default:  nom_end = 1'b1;
    endcase
  end

  // Byte carried by each step
  always_comb begin
    case (eff_step) inside
      ST_HDR1, ST_HDR2:          step_byte = HdrByte;
      ST_DESC, ST_LESC, ST_HESC: step_byte = EscByte;
      ST_DATA:                   step_byte = job_i.data_byte;
      ST_LO:                     step_byte = job_i.crc[7:0];
      ST_HI:                     step_byte = job_i.crc[15:8];
      ST_TAIL1, ST_TAIL2:        step_byte = TailByte;
      default:                   step_byte = 8'h00;
    endcase
  end

  // Next step, byte count and overflow flag
  always_comb begin
    step_d  = step_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    if (go) begin
      unique case (eff_step) inside
        ST_HDR1, ST_HDR2, ST_DESC, ST_DATA, ST_LESC, ST_LO, ST_HESC, ST_HI: begin
          if (room) begin
            count_d = count_q + 16'd1;
            step_d  = nom_end ? ST_START : nom_step;
          end else begin
            ovf_d  = 1'b1;
            step_d = job_i.last ? ST_OVF : ST_START;
          end
        end
        ST_TAIL1: begin
          if (tail_room) begin
            count_d = 16'(cnt_p2);
            step_d  = ST_TAIL2;
          end else begin
            ovf_d  = 1'b1;
            step_d = ST_OVF;
          end
        end
        ST_TAIL2, ST_OVF: begin
          step_d  = ST_START;
          count_d = '0;
          ovf_d   = 1'b0;
        end
        default: step_d = ST_START;
      endcase
    end
  end

  // Result and queue pop for this step
  always_comb begin
    out_push_o = 1'b0;
    job_pop_o  = 1'b0;
    out_item_o = '{out_byte: step_byte, run_last: 1'b0, frame_end: 1'b0, overflow: 1'b0};
    if (go) begin
      unique case (eff_step) inside
        ST_HDR1, ST_HDR2, ST_DESC, ST_DATA, ST_LESC, ST_LO, ST_HESC, ST_HI: begin
          if (room) begin
            out_push_o          = 1'b1;
            out_item_o.run_last = !job_i.last && (nom_end || !more_room);
            job_pop_o           = nom_end;
          end else begin
            job_pop_o = !job_i.last;
          end
        end
        ST_TAIL1: out_push_o = tail_room;
        ST_TAIL2: begin
          out_push_o           = 1'b1;
          out_item_o.run_last  = 1'b1;
          out_item_o.frame_end = 1'b1;
          job_pop_o            = 1'b1;
        end
        ST_OVF: begin
          out_push_o           = 1'b1;
          out_item_o.out_byte  = 8'h00;
          out_item_o.run_last  = 1'b1;
          out_item_o.frame_end = 1'b1;
          out_item_o.overflow  = 1'b1;
          job_pop_o            = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= ST_START;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      step_q  <= step_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

`default_nettype wire

### sv/stuffed_frame_encoder_crc16_unit.sv
// Byte-stuffed frame encoder with CRC-16 (reflected 0xA001, init 0xFFFF). Push payload
// bytes with frame_last on the final one; pop encoded bytes: two 0xAA headers, payload
// with 0xA5 escapes ahead of 0xAA/0x55/0xA5, escaped CRC low and high, then 0x55 0x55.
// A frame that would exceed max_out_len (APB register at address 0) is cut short and
// closes with one overflow result. The front stage takes one byte per cycle while the job
// queue has room, updates the CRC and classifies the byte into that queue; the back
// sequencer turns each job into one encoded byte per cycle while the result queue has
// room, and holds each job until it is done. A job yields 1 or 2 bytes in the body of a
// frame, up to 4 on its first byte and up to 10 on its last. The step at which a frame is
// cut short yields no byte, and a non-final byte that arrives after the cut is dropped
// and yields nothing.
`default_nettype none

module stuffed_frame_encoder_crc16_unit
  import sfe_pkg::*;
#(
  parameter int unsigned JOB_DEPTH = JobDepthDefault,
  parameter int unsigned OUT_DEPTH = OutDepthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input queue side
  input  wire logic                push,
  output logic                     full,
  input  wire in_item_t            in_data_i,
  // result queue side
  output logic                     empty,
  input  wire logic                pop,
  output out_item_t                out_data_o,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  logic        max_len_we;
  logic [15:0] max_out_len_q;
  job_t        job_in, job_out;
  logic        job_push, job_full, job_pop, job_empty;
  logic        out_push, out_full;
  out_item_t   out_item;

  // Configuration register
  assign pready     = 1'b1;
  assign max_len_we = psel && penable && pwrite && (paddr[2] == RegIdxMaxOutLen);
  assign prdata     = (paddr[2] == RegIdxMaxOutLen) ? {16'h0000, max_out_len_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_out_len_q <= MaxOutLenReset;
    end else if (max_len_we) begin
      max_out_len_q <= pwdata[15:0];
    end
  end

  sfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_item_i  (in_data_i),
    .full_o     (full),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  sfe_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  sfe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (job_out),
    .job_valid_i   (!job_empty),
    .job_pop_o     (job_pop),
    .max_out_len_i (max_out_len_q),
    .out_ready_i   (!out_full),
    .out_push_o    (out_push),
    .out_item_o    (out_item)
  );

  sfe_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_item),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_data_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

### sv/sfe_checker.sv
`default_nettype none

module sfe_checker
  import sfe_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_item_t out_data_o
);

  // An overflow result is a bare zero that closes the frame
  a_ovf_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.overflow) |->
      (out_data_o.frame_end && out_data_o.run_last && out_data_o.out_byte == 8'h00))
    else $error("overflow result malformed");

  // A clean frame ends on a tail byte
  a_end_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.frame_end && !out_data_o.overflow) |->
      (out_data_o.out_byte == TailByte))
    else $error("frame end not on tail byte");

  // Frame end always closes the input's run
  a_end_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.frame_end) |-> out_data_o.run_last)
    else $error("frame end without run_last");

  // Hold a waiting result until its transfer
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("waiting result changed");

endmodule

bind stuffed_frame_encoder_crc16_unit sfe_checker u_sfe_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_data_o (out_data_o)
);

`default_nettype wire
